/* rtl/core/sadc_pkg.sv */
package sadc_pkg;

	localparam int unsigned SampleW   = 12;
	localparam int unsigned NumChan   = 8;
	localparam int unsigned ChanW     = 3;
	localparam int unsigned OutShiftW = 13;
	localparam int unsigned CountW    = 8;
	localparam int unsigned CmdBitsW  = 8;
	localparam int unsigned InDataW   = 104;
	localparam int unsigned OutDataW  = 16;

	// clocks needed before a cs rising level decodes a command
	localparam logic [CountW-1:0] MinClocks = 8'd8;
	localparam logic [CountW-1:0] MaxCount  = 8'd255;

	// pin events carried in tuser
	typedef enum logic [2:0] {
		EV_DI   = 3'd0,
		EV_CS   = 3'd1,
		EV_SCLK = 3'd2,
		EV_CONV = 3'd3,
		EV_READ = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_BITS16   = 3'd1,
		ERR_LSBFIRST = 3'd2,
		ERR_CHANNEL  = 3'd3,
		ERR_UNKNOWN  = 3'd4
	} err_t;

	// low nibble of the command byte
	localparam logic [3:0] NibConvert = 4'h0;
	localparam logic [3:0] NibBits16A = 4'h1;
	localparam logic [3:0] NibBits16B = 4'h5;
	localparam logic [3:0] NibLsb     = 4'h4;

	// whole-byte setup commands
	localparam logic [7:0] CmdAutoCal = 8'h08;
	localparam logic [7:0] CmdAcqShort = 8'h0e;
	localparam logic [7:0] CmdSignOn  = 8'h8d;

	localparam logic [1:0] AcqReset = 2'd1;
	localparam logic [1:0] AcqShort = 2'd0;

	typedef struct packed {
		logic       serial_out_bit;
		logic       end_of_conversion;
		err_t       error_code;
		logic       auto_cal_flag;
		logic [1:0] acquisition_code;
		logic       sign_mode;
	} result_t;

endpackage

/* rtl/core/serial_adc_command_interface.sv */
// Serial command interface of a 12-bit-plus-sign A/D converter with an eight-channel
// single-ended mux. Each input transfer is one pin event (tuser: 0 DI, 1 CS, 2 SCLK,
// 3 CONV, 4 read only; 5..7 also act as read only) with the level in tdata[0] and the
// eight channel samples above it. Every input transfer yields exactly one output
// transfer showing DO and the flag state after the event. SCLK at level 1 shifts one
// DI bit into the command (only while fewer than MinClocks clocks are counted) and one bit
// out of the result shift register onto DO; CS at level 1 decodes the command once MinClocks
// clocks have been seen and in either case clears the clock count, command and end-of-conversion flag.
// Timing: an event is registered in the input register and, once the output register
// is free, its result is registered in the output register; one event is taken every
// cycle while the output is not stalled. The state update for an event is a single short decode between those
// two registers. Backpressure on the output stalls the input register in place.
module serial_adc_command_interface (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [0] pin_level, [12:1] sample_ch0 ... [96:85] sample_ch7, [103:97] zero
	input  logic [sadc_pkg::InDataW-1:0]      s_tdata,
	// [2:0] command
	input  logic [2:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] serial_out_bit, [1] end_of_conversion, [4:2] error_code,
	// [5] auto_cal_flag, [7:6] acquisition_code, [8] sign_mode, [15:9] zero
	output logic [sadc_pkg::OutDataW-1:0]     m_tdata
);

	// input register
	logic                                 valid_s1;
	logic [2:0]                           command_s1;
	logic                                 level_s1;
	logic signed [sadc_pkg::SampleW-1:0]  sample_s1 [sadc_pkg::NumChan];

	// output register
	logic                                 valid_s2;
	sadc_pkg::result_t                    result_s2;

	// converter state
	logic [sadc_pkg::CountW-1:0]          clock_count_q;
	logic [sadc_pkg::CmdBitsW-1:0]        command_bits_q;
	logic                                 serial_in_q;
	logic [sadc_pkg::OutShiftW-1:0]       out_shift_q;
	logic                                 out_bit_q;
	logic                                 eoc_q;
	logic                                 sign_en_q;
	logic                                 autocal_q;
	logic [1:0]                           acq_q;
	sadc_pkg::err_t                       error_q;

	// next state
	logic [sadc_pkg::CountW-1:0]          clock_count_d;
	logic [sadc_pkg::CmdBitsW-1:0]        command_bits_d;
	logic                                 serial_in_d;
	logic [sadc_pkg::OutShiftW-1:0]       out_shift_d;
	logic                                 out_bit_d;
	logic                                 eoc_d;
	logic                                 sign_en_d;
	logic                                 autocal_d;
	logic [1:0]                           acq_d;
	sadc_pkg::err_t                       error_d;

	logic                                 advance;
	logic [sadc_pkg::ChanW-1:0]           chan;
	logic [sadc_pkg::SampleW-1:0]         sample_sel;
	logic [sadc_pkg::OutShiftW-1:0]       conv_shift;
	logic                                 conv_bit;
	logic [3:0]                           addr;

	// the event in the input register moves on whenever the output register frees up
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			command_s1 <= s_tuser;
			level_s1   <= s_tdata[0];
			for (int i = 0; i < sadc_pkg::NumChan; i++) begin
				sample_s1[i] <= s_tdata[1 + i*sadc_pkg::SampleW +: sadc_pkg::SampleW];
			end
		end
	end

	// mux address 8..15: bit 2 is the low channel bit, bits 1:0 the high ones
	assign addr       = command_bits_q[7:4];
	assign chan       = {addr[1:0], addr[2]};
	assign sample_sel = sample_s1[chan];

	// load msb first: do gets the top bit now, the rest shift out from bit 0 (sign mode repeats the top bit)
	always_comb begin
		conv_shift = '0;
		if (sign_en_q) begin
			conv_bit = sample_sel[sadc_pkg::SampleW-1];
			for (int i = 0; i < sadc_pkg::SampleW; i++) begin
				conv_shift[i] = sample_sel[sadc_pkg::SampleW-1-i];
			end
		end else begin
			conv_bit = sample_sel[sadc_pkg::SampleW-1];
			for (int i = 0; i < sadc_pkg::SampleW-1; i++) begin
				conv_shift[i] = sample_sel[sadc_pkg::SampleW-2-i];
			end
		end
	end

	// one pin event against the current state
	always_comb begin
		clock_count_d  = clock_count_q;
		command_bits_d = command_bits_q;
		serial_in_d    = serial_in_q;
		out_shift_d    = out_shift_q;
		out_bit_d      = out_bit_q;
		eoc_d          = eoc_q;
		sign_en_d      = sign_en_q;
		autocal_d      = autocal_q;
		acq_d          = acq_q;
		error_d        = error_q;
		unique case (command_s1)
			sadc_pkg::EV_DI: begin
				serial_in_d = level_s1;
			end
			sadc_pkg::EV_CS: begin
				if (level_s1) begin
					if (clock_count_q >= sadc_pkg::MinClocks) begin
						// command decode
						unique case (command_bits_q[3:0])
							sadc_pkg::NibConvert: begin
								if (!addr[3]) begin
									error_d = sadc_pkg::ERR_CHANNEL;
								end else begin
									out_bit_d   = conv_bit;
									out_shift_d = conv_shift;
									error_d     = sadc_pkg::ERR_NONE;
								end
							end
							sadc_pkg::NibBits16A, sadc_pkg::NibBits16B: begin
								error_d = sadc_pkg::ERR_BITS16;
							end
							sadc_pkg::NibLsb: begin
								error_d = sadc_pkg::ERR_LSBFIRST;
							end
							default: begin
								if (command_bits_q == sadc_pkg::CmdAutoCal) begin
									autocal_d = 1'b1;
									error_d   = sadc_pkg::ERR_NONE;
								end else if (command_bits_q == sadc_pkg::CmdAcqShort) begin
									acq_d   = sadc_pkg::AcqShort;
									error_d = sadc_pkg::ERR_NONE;
								end else if (command_bits_q == sadc_pkg::CmdSignOn) begin
									sign_en_d = 1'b1;
									error_d   = sadc_pkg::ERR_NONE;
								end else begin
									error_d = sadc_pkg::ERR_UNKNOWN;
								end
							end
						endcase
					end
					clock_count_d  = '0;
					command_bits_d = '0;
					eoc_d          = 1'b0;
				end
			end
			sadc_pkg::EV_SCLK: begin
				if (level_s1) begin
					if (clock_count_q < sadc_pkg::MinClocks) begin
						command_bits_d = {command_bits_q[sadc_pkg::CmdBitsW-2:0], serial_in_q};
					end
					out_bit_d   = out_shift_q[0];
					out_shift_d = {1'b0, out_shift_q[sadc_pkg::OutShiftW-1:1]};
					// saturating clock count
					if (clock_count_q != sadc_pkg::MaxCount) begin
						clock_count_d = clock_count_q + 8'd1;
					end
				end
			end
			sadc_pkg::EV_CONV: begin
				eoc_d = 1'b1;
			end
			default: begin
				// read only and unused codes leave the state alone
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_count_q  <= '0;
			command_bits_q <= '0;
			serial_in_q    <= 1'b0;
			out_shift_q    <= '0;
			out_bit_q      <= 1'b0;
			eoc_q          <= 1'b0;
			sign_en_q      <= 1'b1;
			autocal_q      <= 1'b0;
			acq_q          <= sadc_pkg::AcqReset;
			error_q        <= sadc_pkg::ERR_NONE;
		end else if (advance) begin
			clock_count_q  <= clock_count_d;
			command_bits_q <= command_bits_d;
			serial_in_q    <= serial_in_d;
			out_shift_q    <= out_shift_d;
			out_bit_q      <= out_bit_d;
			eoc_q          <= eoc_d;
			sign_en_q      <= sign_en_d;
			autocal_q      <= autocal_d;
			acq_q          <= acq_d;
			error_q        <= error_d;
		end
	end

	// output register holds a result until the downstream transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.serial_out_bit    <= out_bit_d;
			result_s2.end_of_conversion <= eoc_d;
			result_s2.error_code        <= error_d;
			result_s2.auto_cal_flag     <= autocal_d;
			result_s2.acquisition_code  <= acq_d;
			result_s2.sign_mode         <= sign_en_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0,
		result_s2.sign_mode,
		result_s2.acquisition_code,
		result_s2.auto_cal_flag,
		result_s2.error_code,
		result_s2.end_of_conversion,
		result_s2.serial_out_bit};

`ifndef SYNTHESIS
	// a cs high event always leaves the count, command and eoc cleared
	a_cs_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && command_s1 == sadc_pkg::EV_CS && level_s1
		|=> clock_count_q == '0 && command_bits_q == '0 && !eoc_q)
		else $error("cs did not clear the serial state");

	// an event leaving the input register always lands in the output register
	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("processed event lost before the output register");

	// input is held off only while both registers are full and the output stalls
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled without output backpressure");
`endif

endmodule
